// ===== rtl/mac_learning_bridge_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the learning bridge table
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAC_LEARNING_BRIDGE_TABLE_UNIT_MACROS_SVH
`define MAC_LEARNING_BRIDGE_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MLBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlbt check failed");
`define MLBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlbt check failed");
`else
`define MLBT_ASSERT_IMP(lbl, ante, cons)
`define MLBT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/mlbt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlbt_pkg
// Shared types and constants of the learning bridge table.
// ----------------------------------------------------------------------------
`default_nettype none
package mlbt_pkg;

  localparam int ADDR_W = 48;
  localparam int PORT_W = 3;
  localparam int LIFE_W = 8;
  localparam int MASK_W = 8;
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;

  localparam logic [LIFE_W-1:0] LIFE_RST    = 8'd30;
  localparam logic [ADDR_W-1:0] NO_ENTRY_RST = 48'hFFFF_FFFF_FFFF;
  localparam logic [MASK_W-1:0] PORT_EN_RST = 8'hFF;

  typedef enum logic [1:0] {
    REG_LIFETIME = 2'd0,
    REG_NO_ENTRY = 2'd1,
    REG_PORT_EN  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LEARN,
    ST_RESULT,
    ST_AGE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [LIFE_W-1:0] life;
  } entry_t;

  typedef struct packed {
    logic src_hit;
    logic dst_hit;
    logic free;
  } probe_t;

  typedef struct packed {
    logic [LIFE_W-1:0] lifetime;
    logic [ADDR_W-1:0] no_entry;
    logic [MASK_W-1:0] port_en;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/mac_learning_bridge_table_unit.sv =====
// ----------------------------------------------------------------------------
// mac_learning_bridge_table_unit
// Learning bridge forwarding table with aging, APB-style register port.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the table and holds in_ready
// low until it ends. Every item walks the table one entry per cycle through one
// shared compare/decrement unit, and that walk sets the timing. A frame passes
// the scan walk, the learn write and the result state before its result is
// registered on the output, and the next item can be transferred once the
// block is back in idle. An aging tick gives no result, and the next item can
// be transferred once its walk ends. The next item may be transferred while the
// previous result still waits on the output register; a frame that finishes
// while that result still waits holds in_ready low until out_ready frees it.
`default_nettype none
module mac_learning_bridge_table_unit #(
  parameter int TABLE_ENTRIES = 16,
  parameter int PORT_COUNT    = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mlbt_pkg::CFG_AW-1:0]       paddr,
  input  wire logic [mlbt_pkg::CFG_DW-1:0]       pwdata,
  output logic [mlbt_pkg::CFG_DW-1:0]            prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_operation,
  input  wire logic [mlbt_pkg::ADDR_W-1:0]       in_source_address,
  input  wire logic [mlbt_pkg::ADDR_W-1:0]       in_destination_address,
  input  wire logic [mlbt_pkg::PORT_W-1:0]       in_ingress_port,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mlbt_pkg::MASK_W-1:0]            out_forward_mask,
  output logic                                   out_flooded,
  output logic                                   out_learn_dropped
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  mlbt_pkg::cfg_t       cfg_r;
  mlbt_pkg::reg_idx_t   reg_idx;
  logic                 cfg_wr;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [IDX_W-1:0]     ram_raddr;
  mlbt_pkg::entry_t     ram_wdata;
  mlbt_pkg::entry_t     ram_rdata;
  mlbt_pkg::entry_t     aged;
  mlbt_pkg::probe_t     probe;
  logic [mlbt_pkg::ADDR_W-1:0] key_src;
  logic [mlbt_pkg::ADDR_W-1:0] key_dst;

  assign pready  = 1'b1;
  assign reg_idx = mlbt_pkg::reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lifetime <= mlbt_pkg::LIFE_RST;
      cfg_r.no_entry <= mlbt_pkg::NO_ENTRY_RST;
      cfg_r.port_en  <= mlbt_pkg::PORT_EN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mlbt_pkg::REG_LIFETIME: cfg_r.lifetime <= pwdata[mlbt_pkg::LIFE_W-1:0];
        mlbt_pkg::REG_NO_ENTRY: cfg_r.no_entry <= pwdata[mlbt_pkg::ADDR_W-1:0];
        mlbt_pkg::REG_PORT_EN:  cfg_r.port_en  <= pwdata[mlbt_pkg::MASK_W-1:0];
        default:                cfg_r          <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mlbt_pkg::REG_LIFETIME: prdata = mlbt_pkg::CFG_DW'(cfg_r.lifetime);
      mlbt_pkg::REG_NO_ENTRY: prdata = mlbt_pkg::CFG_DW'(cfg_r.no_entry);
      mlbt_pkg::REG_PORT_EN:  prdata = mlbt_pkg::CFG_DW'(cfg_r.port_en);
      default:                prdata = '0;
    endcase
  end

  mlbt_entry_ram #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mlbt_entry_unit u_unit (
    .entry(ram_rdata),
    .src  (key_src),
    .dst  (key_dst),
    .probe(probe),
    .aged (aged)
  );

  mlbt_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PORT_COUNT   (PORT_COUNT),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_source_address     (in_source_address),
    .in_destination_address(in_destination_address),
    .in_ingress_port       (in_ingress_port),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_forward_mask      (out_forward_mask),
    .out_flooded           (out_flooded),
    .out_learn_dropped     (out_learn_dropped),
    .ram_we                (ram_we),
    .ram_waddr             (ram_waddr),
    .ram_wdata             (ram_wdata),
    .ram_raddr             (ram_raddr),
    .ram_rdata             (ram_rdata),
    .key_src               (key_src),
    .key_dst               (key_dst),
    .probe                 (probe),
    .aged                  (aged)
  );

endmodule
`default_nettype wire

// ===== rtl/mlbt_entry_ram.sv =====
// ----------------------------------------------------------------------------
// mlbt_entry_ram
// Table storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mlbt_entry_ram #(
  parameter int TABLE_ENTRIES = 16,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [IDX_W-1:0]      waddr,
  input  wire mlbt_pkg::entry_t      wdata,
  input  wire logic [IDX_W-1:0]      raddr,
  output mlbt_pkg::entry_t           rdata
);

  mlbt_pkg::entry_t mem_r [TABLE_ENTRIES];
  mlbt_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/mlbt_entry_unit.sv =====
// ----------------------------------------------------------------------------
// mlbt_entry_unit
// Shared per-entry unit: address compares and lifetime decrement.
// ----------------------------------------------------------------------------
`default_nettype none
module mlbt_entry_unit (
  input  wire mlbt_pkg::entry_t                  entry,
  input  wire logic [mlbt_pkg::ADDR_W-1:0]       src,
  input  wire logic [mlbt_pkg::ADDR_W-1:0]       dst,
  output mlbt_pkg::probe_t                       probe,
  output mlbt_pkg::entry_t                       aged
);

  always_comb begin
    probe.src_hit = entry.valid && (entry.addr == src);
    probe.dst_hit = entry.valid && (entry.addr == dst);
    probe.free    = !entry.valid;
  end

  // lifetime of 0 or 1 expires on this tick
  always_comb begin
    aged = entry;
    if (entry.valid) begin
      if (entry.life <= mlbt_pkg::LIFE_W'(1)) begin
        aged.valid = 1'b0;
        aged.life  = '0;
      end else begin
        aged.life = entry.life - mlbt_pkg::LIFE_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mlbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlbt_ctrl
// Sequencer: clearing pass, table walk for learn/lookup and aging, result reg.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mac_learning_bridge_table_unit_macros.svh"
module mlbt_ctrl #(
  parameter int TABLE_ENTRIES = 16,
  parameter int PORT_COUNT    = 8,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mlbt_pkg::cfg_t                    cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_operation,
  input  wire logic [mlbt_pkg::ADDR_W-1:0]       in_source_address,
  input  wire logic [mlbt_pkg::ADDR_W-1:0]       in_destination_address,
  input  wire logic [mlbt_pkg::PORT_W-1:0]       in_ingress_port,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mlbt_pkg::MASK_W-1:0]            out_forward_mask,
  output logic                                   out_flooded,
  output logic                                   out_learn_dropped,
  output logic                                   ram_we,
  output logic [IDX_W-1:0]                       ram_waddr,
  output mlbt_pkg::entry_t                       ram_wdata,
  output logic [IDX_W-1:0]                       ram_raddr,
  input  wire mlbt_pkg::entry_t                  ram_rdata,
  output logic [mlbt_pkg::ADDR_W-1:0]            key_src,
  output logic [mlbt_pkg::ADDR_W-1:0]            key_dst,
  input  wire mlbt_pkg::probe_t                  probe,
  input  wire mlbt_pkg::entry_t                  aged
);

  localparam logic [IDX_W:0] CNT_END = (IDX_W+1)'(TABLE_ENTRIES);

  mlbt_pkg::state_t state_r, state_nxt;

  logic [IDX_W:0]                 cnt_r;
  logic                           cnt_done;
  logic                           issue;
  logic                           pend_r;
  logic [IDX_W-1:0]               pend_idx_r;
  logic [mlbt_pkg::ADDR_W-1:0]    src_r;
  logic [mlbt_pkg::ADDR_W-1:0]    dst_r;
  logic [mlbt_pkg::PORT_W-1:0]    port_r;
  logic                           src_found_r;
  logic [IDX_W-1:0]               src_idx_r;
  logic                           free_found_r;
  logic [IDX_W-1:0]               free_idx_r;
  logic                           dst_found_r;
  logic [mlbt_pkg::PORT_W-1:0]    dst_port_r;
  logic                           dropped_r;
  logic                           out_valid_r;
  logic [mlbt_pkg::MASK_W-1:0]    out_mask_r;
  logic                           out_flood_r;
  logic                           out_drop_r;
  logic                           out_free;
  logic                           accept;
  logic                           learn_ok;
  logic [mlbt_pkg::MASK_W-1:0]    exist_mask;
  logic                           self_hit;
  logic                           known;
  logic [mlbt_pkg::PORT_W-1:0]    known_port;
  logic [mlbt_pkg::MASK_W-1:0]    res_mask;

  assign cnt_done = (cnt_r == CNT_END);
  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign learn_ok = src_found_r || free_found_r;
  assign key_src  = src_r;
  assign key_dst  = dst_r;

  always_comb begin
    for (int i = 0; i < mlbt_pkg::MASK_W; i++) begin
      exist_mask[i] = (i < PORT_COUNT);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlbt_pkg::ST_CLEAR:  if (cnt_done) state_nxt = mlbt_pkg::ST_IDLE;
      mlbt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_operation ? mlbt_pkg::ST_AGE : mlbt_pkg::ST_SCAN;
        end
      end
      mlbt_pkg::ST_SCAN:   if (cnt_done) state_nxt = mlbt_pkg::ST_LEARN;
      mlbt_pkg::ST_LEARN:  state_nxt = mlbt_pkg::ST_RESULT;
      mlbt_pkg::ST_RESULT: if (out_free) state_nxt = mlbt_pkg::ST_IDLE;
      mlbt_pkg::ST_AGE:    if (cnt_done) state_nxt = mlbt_pkg::ST_IDLE;
      default:             state_nxt = mlbt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[IDX_W-1:0];
    ram_wdata = '0;
    ram_raddr = cnt_r[IDX_W-1:0];
    unique case (state_r)
      mlbt_pkg::ST_CLEAR: begin
        ram_we = !cnt_done;
      end
      mlbt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      mlbt_pkg::ST_SCAN: begin
        issue = !cnt_done;
      end
      mlbt_pkg::ST_LEARN: begin
        ram_we          = learn_ok;
        ram_waddr       = src_found_r ? src_idx_r : free_idx_r;
        ram_wdata.valid = 1'b1;
        ram_wdata.addr  = src_r;
        ram_wdata.port  = port_r;
        ram_wdata.life  = cfg.lifetime;
      end
      mlbt_pkg::ST_RESULT: begin
        in_ready = 1'b0;
      end
      mlbt_pkg::ST_AGE: begin
        issue     = !cnt_done;
        ram_we    = pend_r && ram_rdata.valid;
        ram_waddr = pend_idx_r;
        ram_wdata = aged;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result of the lookup; a hit on the source just learned uses the ingress port
  always_comb begin
    self_hit   = !dropped_r && (dst_r == src_r);
    known      = (dst_r != cfg.no_entry) && (self_hit || dst_found_r);
    known_port = self_hit ? port_r : dst_port_r;
    if (known) begin
      res_mask = mlbt_pkg::MASK_W'(1) << known_port;
    end else begin
      res_mask = cfg.port_en & ~(mlbt_pkg::MASK_W'(1) << port_r);
    end
    res_mask = res_mask & exist_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlbt_pkg::ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (accept) begin
        cnt_r <= '0;
      end else if (issue || (state_r == mlbt_pkg::ST_CLEAR && !cnt_done)) begin
        cnt_r <= cnt_r + (IDX_W+1)'(1);
      end
      if (state_r == mlbt_pkg::ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= cnt_r[IDX_W-1:0];
    if (accept) begin
      src_r        <= in_source_address;
      dst_r        <= in_destination_address;
      port_r       <= in_ingress_port;
      src_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      dst_found_r  <= 1'b0;
    end else if (state_r == mlbt_pkg::ST_SCAN && pend_r) begin
      if (probe.src_hit && !src_found_r) begin
        src_found_r <= 1'b1;
        src_idx_r   <= pend_idx_r;
      end
      // lowest free entry wins
      if (probe.free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= pend_idx_r;
      end
      if (probe.dst_hit) begin
        dst_found_r <= 1'b1;
        dst_port_r  <= ram_rdata.port;
      end
    end
    if (state_r == mlbt_pkg::ST_LEARN) begin
      dropped_r <= !learn_ok;
    end
    if (state_r == mlbt_pkg::ST_RESULT && out_free) begin
      out_mask_r  <= res_mask;
      out_flood_r <= !known;
      out_drop_r  <= dropped_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_forward_mask  = out_mask_r;
  assign out_flooded       = out_flood_r;
  assign out_learn_dropped = out_drop_r;

  `MLBT_ASSERT_IMP(a_no_write_in_scan, state_r == mlbt_pkg::ST_SCAN, !ram_we)
  `MLBT_ASSERT_IMP(a_drop_no_write, state_r == mlbt_pkg::ST_LEARN && !learn_ok, !ram_we)
  `MLBT_ASSERT_IMP(a_idle_no_pending, in_ready, !pend_r)
  `MLBT_ASSERT_NXT(a_frame_starts_scan, accept && !in_operation, state_r == mlbt_pkg::ST_SCAN)

endmodule
`default_nettype wire
